// File: sv/ipdfx_pkg.sv
// Package for the IPD frame extractor: result and config write types, phase codes and constants.
package ipdfx_pkg;

    localparam int unsigned TOKEN_MAX    = 8;
    localparam int unsigned TOK_POS_W    = $clog2(TOKEN_MAX);
    localparam int unsigned TOK_BYTES_W  = 8 * TOKEN_MAX;
    localparam int unsigned TOK_LEN_W    = 4;
    localparam int unsigned LEN_W        = 16;
    localparam int unsigned STATUS_W     = 10;
    localparam int unsigned CFG_IDX_W    = 1;
    localparam int unsigned CFG_DATA_W   = 64;

    localparam logic [7:0]        CHAR_COLON    = 8'h3A;
    localparam logic [7:0]        CHAR_ZERO     = 8'h30;
    localparam logic [7:0]        CHAR_NINE     = 8'h39;
    localparam logic [LEN_W-1:0]  LEN_SAT       = 16'hFFFF;
    localparam logic [LEN_W-1:0]  OK_MIN_LEN    = 16'd20;
    localparam logic [LEN_W-1:0]  STATUS_FIRST  = 16'd9;
    localparam logic [LEN_W-1:0]  STATUS_END    = 16'd12;

    localparam logic [TOK_BYTES_W-1:0] TOKEN_BYTES_RST  = 64'h0000_002C_4450_492B;
    localparam logic [TOK_LEN_W-1:0]   TOKEN_LENGTH_RST = 4'd5;

    localparam logic [CFG_IDX_W-1:0] CFG_TOKEN_BYTES  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_TOKEN_LENGTH = 1'b1;

    typedef enum logic [1:0] {
        PH_SEARCH  = 2'd0,
        PH_LENGTH  = 2'd1,
        PH_PAYLOAD = 2'd2
    } t_phase;

    typedef struct packed {
        logic                 wr_en;
        logic [CFG_IDX_W-1:0] index;
        logic [CFG_DATA_W-1:0] data;
    } t_cfg_wr;

    typedef struct packed {
        logic [7:0]          payload_byte;
        logic                is_last;
        logic                frame_ok;
        logic [STATUS_W-1:0] status_code;
    } t_result;

endpackage

// File: sv/ipd_frame_extractor_core.sv
// Top level of the IPD frame extractor: modem byte stream in, payload bytes out.
//
// Usage:
//   Slave stream: one received modem character per transaction in tdata[7:0].
//   The block hunts for the configured token (reset "+IPD,"), reads a decimal
//   length up to ':' and then forwards exactly that many payload bytes on the
//   master stream, tlast marking the final one. On the final byte tuser carries
//   frame_ok (length at least 20) and tdata carries the status code read from
//   payload offsets 9 to 11. A zero length frame yields one empty last byte.
//   Throughput: one byte per clock while the skid entry is free; a result is
//   registered in the output register, or in the skid entry under a stall.
//   Stall: the output register plus one skid entry absorb a stalled receiver;
//   tready on the slave side drops only while the skid entry is occupied.
//   Reset (synchronous, active low): token and token length return to their
//   defaults, search restarts at position zero and both buffers empty.
//   Configuration: write port, index 0 token bytes, index 1 token length;
//   write only while the stream is idle.
module ipd_frame_extractor_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // configuration write port
    input  logic        i_cfg_wr_en,
    input  logic [0:0]  i_cfg_index,
    input  logic [63:0] i_cfg_data,
    // slave stream: tdata[7:0] rx_byte
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [7:0]  i_s_axis_tdata,
    // master stream: tdata[7:0] payload_byte, [17:8] status_code, [23:18] zero
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [23:0] o_m_axis_tdata,
    output logic        o_m_axis_tlast,
    // tuser[0] frame_ok
    output logic [0:0]  o_m_axis_tuser
);
    import ipdfx_pkg::*;

    t_cfg_wr cfg;
    t_result res;
    t_result out_res;
    logic    res_valid;
    logic    buf_ready;
    logic    accept;

    assign cfg.wr_en = i_cfg_wr_en;
    assign cfg.index = i_cfg_index;
    assign cfg.data  = i_cfg_data;

    // advance the parser only on a completed slave transaction
    assign accept          = i_s_axis_tvalid && buf_ready;
    assign o_s_axis_tready = buf_ready;

    ipdfx_parser u_parser (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (cfg),
        .i_accept    (accept),
        .i_rx_byte   (i_s_axis_tdata),
        .o_res_valid (res_valid),
        .o_res       (res)
    );

    ipdfx_out_buf u_out_buf (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_res_valid (res_valid),
        .i_res       (res),
        .o_in_ready  (buf_ready),
        .o_valid     (o_m_axis_tvalid),
        .i_ready     (i_m_axis_tready),
        .o_res       (out_res)
    );

    assign o_m_axis_tdata    = {6'b0, out_res.status_code, out_res.payload_byte};
    assign o_m_axis_tlast    = out_res.is_last;
    assign o_m_axis_tuser[0] = out_res.frame_ok;

endmodule

// File: sv/ipdfx_parser.sv
// Byte parser: token hunt, length digits and payload counting, one accepted byte per cycle.
module ipdfx_parser (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  ipdfx_pkg::t_cfg_wr  i_cfg,
    input  logic                i_accept,
    input  logic [7:0]          i_rx_byte,
    output logic                o_res_valid,
    output ipdfx_pkg::t_result  o_res
);
    import ipdfx_pkg::*;

    logic [TOK_BYTES_W-1:0] r_token_bytes;
    logic [TOK_LEN_W-1:0]   r_token_length;
    t_phase                 r_phase,        n_phase;
    logic [TOK_POS_W-1:0]   r_match_pos,    n_match_pos;
    logic [LEN_W-1:0]       r_len,          n_len;
    logic                   r_len_done,     n_len_done;
    logic [LEN_W-1:0]       r_seen,         n_seen;
    logic [STATUS_W-1:0]    r_status,       n_status;
    logic                   r_status_done,  n_status_done;

    logic [TOK_LEN_W-1:0]   used_len;
    logic [7:0]             tok_char;
    logic                   is_digit;
    logic [3:0]             digit;
    logic [TOK_LEN_W-1:0]   pos_inc;
    logic [LEN_W+3:0]       len_mac;
    logic [STATUS_W+3:0]    status_mac;
    logic [LEN_W-1:0]       seen_inc;
    logic                   in_status_win;

    always_comb begin
        if (r_token_length == '0) begin
            used_len = TOK_LEN_W'(1);
        end else if (r_token_length > TOK_LEN_W'(TOKEN_MAX)) begin
            used_len = TOK_LEN_W'(TOKEN_MAX);
        end else begin
            used_len = r_token_length;
        end
    end

    assign tok_char      = r_token_bytes[{r_match_pos, 3'b000} +: 8];
    assign is_digit      = (i_rx_byte >= CHAR_ZERO) && (i_rx_byte <= CHAR_NINE);
    assign digit         = 4'(i_rx_byte - CHAR_ZERO);
    assign pos_inc       = TOK_LEN_W'({1'b0, r_match_pos}) + TOK_LEN_W'(1);
    assign len_mac       = (LEN_W+4)'(r_len) * (LEN_W+4)'(10) + (LEN_W+4)'(digit);
    assign status_mac    = (STATUS_W+4)'(r_status) * (STATUS_W+4)'(10)
                         + (STATUS_W+4)'(digit);
    assign seen_inc      = r_seen + LEN_W'(1);
    assign in_status_win = (r_seen >= STATUS_FIRST) && (r_seen < STATUS_END);

    always_comb begin
        n_phase       = r_phase;
        n_match_pos   = r_match_pos;
        n_len         = r_len;
        n_len_done    = r_len_done;
        n_seen        = r_seen;
        n_status      = r_status;
        n_status_done = r_status_done;
        o_res_valid   = 1'b0;
        o_res         = '0;
        if (i_accept) begin
            unique case (r_phase)
                PH_SEARCH: begin
                    if (tok_char == i_rx_byte) begin
                        if (pos_inc >= used_len) begin
                            n_match_pos = '0;
                            n_phase     = PH_LENGTH;
                            n_len       = '0;
                            n_len_done  = 1'b0;
                        end else begin
                            n_match_pos = TOK_POS_W'(pos_inc);
                        end
                    end else begin
                        n_match_pos = '0;
                    end
                end
                PH_LENGTH: begin
                    if (i_rx_byte == CHAR_COLON) begin
                        n_seen        = '0;
                        n_status      = '0;
                        n_status_done = 1'b0;
                        if (r_len == '0) begin
                            n_phase       = PH_SEARCH;
                            o_res_valid   = 1'b1;
                            o_res.is_last = 1'b1;
                        end else begin
                            n_phase = PH_PAYLOAD;
                        end
                    end else if (!r_len_done) begin
                        if (is_digit) begin
                            n_len = (len_mac > (LEN_W+4)'(LEN_SAT)) ? LEN_SAT
                                                                     : LEN_W'(len_mac);
                        end else begin
                            n_len_done = 1'b1;
                        end
                    end
                end
                PH_PAYLOAD: begin
                    if (in_status_win && !r_status_done) begin
                        if (is_digit) begin
                            n_status = status_mac[STATUS_W-1:0];
                        end else begin
                            n_status_done = 1'b1;
                        end
                    end
                    n_seen             = seen_inc;
                    o_res_valid        = 1'b1;
                    o_res.payload_byte = i_rx_byte;
                    if (seen_inc >= r_len) begin
                        n_phase           = PH_SEARCH;
                        n_match_pos       = '0;
                        o_res.is_last     = 1'b1;
                        o_res.frame_ok    = (r_len >= OK_MIN_LEN);
                        o_res.status_code = n_status;
                    end
                end
                default: begin
                    n_phase     = PH_SEARCH;
                    n_match_pos = '0;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_token_bytes  <= TOKEN_BYTES_RST;
            r_token_length <= TOKEN_LENGTH_RST;
            r_phase        <= PH_SEARCH;
            r_match_pos    <= '0;
            r_len          <= '0;
            r_len_done     <= 1'b0;
            r_seen         <= '0;
            r_status       <= '0;
            r_status_done  <= 1'b0;
        end else begin
            if (i_cfg.wr_en) begin
                unique case (i_cfg.index)
                    CFG_TOKEN_BYTES:  r_token_bytes  <= i_cfg.data;
                    CFG_TOKEN_LENGTH: r_token_length <= i_cfg.data[TOK_LEN_W-1:0];
                    default: ;
                endcase
            end
            r_phase       <= n_phase;
            r_match_pos   <= n_match_pos;
            r_len         <= n_len;
            r_len_done    <= n_len_done;
            r_seen        <= n_seen;
            r_status      <= n_status;
            r_status_done <= n_status_done;
        end
    end

endmodule

// File: sv/ipdfx_out_buf.sv
// Output register with a skid stage so the parser keeps running under a brief stall.
module ipdfx_out_buf (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_res_valid,
    input  ipdfx_pkg::t_result i_res,
    output logic               o_in_ready,
    output logic               o_valid,
    input  logic               i_ready,
    output ipdfx_pkg::t_result o_res
);
    import ipdfx_pkg::*;

    logic    r_out_valid;
    logic    r_skid_valid;
    t_result r_out;
    t_result r_skid;
    logic    out_taken;

    assign out_taken  = r_out_valid && i_ready;
    assign o_in_ready = !r_skid_valid;
    assign o_valid    = r_out_valid;
    assign o_res      = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else begin
            if (r_skid_valid) begin
                if (out_taken) begin
                    r_skid_valid <= 1'b0;
                end
            end else if (i_res_valid) begin
                if (r_out_valid && !i_ready) begin
                    r_skid_valid <= 1'b1;
                end else begin
                    r_out_valid <= 1'b1;
                end
            end else if (out_taken) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_skid_valid) begin
            if (out_taken) begin
                r_out <= r_skid;
            end
        end else if (i_res_valid) begin
            if (r_out_valid && !i_ready) begin
                r_skid <= i_res;
            end else begin
                r_out <= i_res;
            end
        end
    end

endmodule

// File: sim/tb_ipd_frame_extractor_core.sv
// Self-checking testbench for the IPD frame extractor core: stream driver, predictor, checker.
`timescale 1ns / 1ps

module tb_ipd_frame_extractor_core;
    import ipdfx_pkg::*;

    localparam int unsigned CYCLE_LIMIT   = 600000;
    localparam int unsigned SETTLE_CYCLES = 4;
    localparam int unsigned RANDOM_CHUNK  = 50;
    localparam int unsigned FLUSH_BYTES   = 100;
    localparam int unsigned OPEN_PAYLOAD  = 30;

    // ------------------------------------------------------------------
    // Clock, reset and block inputs; every input is known from time zero
    // ------------------------------------------------------------------
    logic                  i_clk     = 1'b0;
    logic                  i_rst_n   = 1'b0;
    logic                  cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data  = '0;
    logic                  s_tvalid  = 1'b0;
    logic [7:0]            s_tdata   = 8'h00;
    logic                  m_tready  = 1'b0;

    logic                  s_tready;
    logic                  m_tvalid;
    logic [23:0]           m_tdata;
    logic                  m_tlast;
    logic [0:0]            m_tuser;

    ipd_frame_extractor_core DUT (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_wr_en     (cfg_wr_en),
        .i_cfg_index     (cfg_index),
        .i_cfg_data      (cfg_data),
        .i_s_axis_tvalid (s_tvalid),
        .o_s_axis_tready (s_tready),
        .i_s_axis_tdata  (s_tdata),   // [7:0] rx_byte
        .o_m_axis_tvalid (m_tvalid),
        .i_m_axis_tready (m_tready),
        .o_m_axis_tdata  (m_tdata),   // [7:0] payload_byte, [17:8] status_code, [23:18] zero
        .o_m_axis_tlast  (m_tlast),
        .o_m_axis_tuser  (m_tuser)    // [0] frame_ok
    );

    initial begin
        forever #6 i_clk = ~i_clk;
    end

    // ------------------------------------------------------------------
    // Shared testbench state
    // ------------------------------------------------------------------
    logic [7:0]  rx_stream[$];          // modem bytes still to be offered
    t_result     expected_payload[$];   // results the block still owes us
    int unsigned fail_count = 0;
    bit          send_idle  = 1'b1;     // sender inserts random gaps
    bit          recv_idle  = 1'b1;     // receiver stalls at random
    bit          rx_fire    = 1'b0;     // slave transaction at the last rising edge
    bit          m_fire     = 1'b0;     // master transaction at the last rising edge
    int unsigned tx_gap     = 0;
    int unsigned stall_left = 0;

    // Predictor copy of the configuration and of the deframing state
    logic [TOK_BYTES_W-1:0] tok_bytes     = TOKEN_BYTES_RST;
    logic [TOK_LEN_W-1:0]   tok_len       = TOKEN_LENGTH_RST;
    t_phase                 ph            = PH_SEARCH;
    logic [3:0]             match_pos     = '0;
    logic [LEN_W-1:0]       len_val       = '0;
    logic                   len_done      = 1'b0;
    logic [LEN_W-1:0]       payload_count = '0;
    logic [STATUS_W-1:0]    status_acc    = '0;
    logic                   status_done   = 1'b0;

    // Token length actually in force: zero counts as one, anything past the maximum clamps
    function automatic int unsigned token_span();
        if (tok_len == 0) return 1;
        if (tok_len > TOKEN_MAX) return TOKEN_MAX;
        return tok_len;
    endfunction

    function automatic bit is_numeral(input logic [7:0] c);
        return (c >= CHAR_ZERO) && (c <= CHAR_NINE);
    endfunction

    // Advance the predicted deframer by one accepted byte; queue any result it owes
    function automatic void deframe_byte(input logic [7:0] c);
        logic [7:0]  tok_char;
        int unsigned grown;
        t_result     res;
        res = '0;
        case (ph)
            PH_SEARCH: begin
                tok_char = tok_bytes[8 * match_pos[2:0] +: 8];
                if (tok_char == c) begin
                    match_pos = match_pos + 4'd1;
                    if (match_pos >= token_span()) begin
                        match_pos = '0;
                        ph        = PH_LENGTH;
                        len_val   = '0;
                        len_done  = 1'b0;
                    end
                end else begin
                    // naive matcher: drop back to the start, do not retry this byte
                    match_pos = '0;
                end
            end
            PH_LENGTH: begin
                if (c == CHAR_COLON) begin
                    payload_count = '0;
                    status_acc    = '0;
                    status_done   = 1'b0;
                    if (len_val == 0) begin
                        // empty frame: one bare last result, then hunt again
                        ph          = PH_SEARCH;
                        res.is_last = 1'b1;
                        expected_payload.push_back(res);
                    end else begin
                        ph = PH_PAYLOAD;
                    end
                end else if (!len_done) begin
                    if (is_numeral(c)) begin
                        grown   = len_val * 10 + (c - CHAR_ZERO);
                        len_val = (grown > LEN_SAT) ? LEN_SAT : grown[LEN_W-1:0];
                    end else begin
                        len_done = 1'b1;
                    end
                end
            end
            PH_PAYLOAD: begin
                if (payload_count >= STATUS_FIRST && payload_count < STATUS_END
                        && !status_done) begin
                    if (is_numeral(c))
                        status_acc = STATUS_W'(status_acc * 10 + (c - CHAR_ZERO));
                    else
                        status_done = 1'b1;
                end
                payload_count    = payload_count + 1'b1;
                res.payload_byte = c;
                if (payload_count >= len_val) begin
                    res.is_last     = 1'b1;
                    res.frame_ok    = (len_val >= OK_MIN_LEN);
                    res.status_code = status_acc;
                    ph              = PH_SEARCH;
                    match_pos       = '0;
                end
                expected_payload.push_back(res);
            end
            default: begin
                ph        = PH_SEARCH;
                match_pos = '0;
            end
        endcase
    endfunction

    function automatic void check_field(input string name, input logic [15:0] want,
                                        input logic [15:0] got);
        if (got !== want) begin
            $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
            fail_count++;
        end
    endfunction

    // ------------------------------------------------------------------
    // Monitor: sample both handshakes at the rising edge, predict, compare
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        t_result want;
        if (!i_rst_n) begin
            rx_fire       = 1'b0;
            m_fire        = 1'b0;
            tok_bytes     = TOKEN_BYTES_RST;
            tok_len       = TOKEN_LENGTH_RST;
            ph            = PH_SEARCH;
            match_pos     = '0;
            len_val       = '0;
            len_done      = 1'b0;
            payload_count = '0;
            status_acc    = '0;
            status_done   = 1'b0;
        end else begin
            rx_fire = s_tvalid && s_tready;
            m_fire  = m_tvalid && m_tready;
            // predict first so the order of the two checks never matters
            if (rx_fire) deframe_byte(s_tdata);
            if (m_fire) begin
                if (expected_payload.size() == 0) begin
                    $error("result with nothing expected: tdata 0x%0h", m_tdata);
                    fail_count++;
                end else begin
                    want = expected_payload.pop_front();
                    check_field("payload_byte", want.payload_byte, m_tdata[7:0]);
                    check_field("status_code", want.status_code, m_tdata[17:8]);
                    check_field("tdata padding", 16'h0, m_tdata[23:18]);
                    check_field("is_last", want.is_last, m_tlast);
                    check_field("frame_ok", want.frame_ok, m_tuser[0]);
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Driver: hold each byte until its transaction, then, if send_idle is set, insert a random gap of idle cycles
    // ------------------------------------------------------------------
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            s_tvalid <= 1'b0;
            tx_gap = 0;
        end else if (!s_tvalid || rx_fire) begin
            if (tx_gap > 0) begin
                s_tvalid <= 1'b0;
                tx_gap--;
            end else if (rx_stream.size() > 0) begin
                s_tdata  <= rx_stream.pop_front();
                s_tvalid <= 1'b1;
                tx_gap = send_idle ? $urandom_range(0, 9) : 0;
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // Receiver: after each result, stall for a random gap if recv_idle is set
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            m_tready <= 1'b0;
            stall_left = 0;
        end else begin
            if (m_fire) stall_left = recv_idle ? $urandom_range(0, 9) : 0;
            if (stall_left > 0) begin
                m_tready <= 1'b0;
                stall_left--;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------
    function automatic logic [7:0] any_byte();
        return 8'($urandom_range(0, 255));
    endfunction

    function automatic logic [7:0] digit_char();
        return 8'(CHAR_ZERO + $urandom_range(0, 9));
    endfunction

    function automatic void queue_text(input string s);
        for (int i = 0; i < s.len(); i++) rx_stream.push_back(s[i]);
    endfunction

    function automatic void queue_token();
        for (int i = 0; i < token_span(); i++) rx_stream.push_back(tok_bytes[8 * i +: 8]);
    endfunction

    // Well-formed frame under the current token, random content
    function automatic void queue_frame();
        int unsigned plen;
        bit          status_digits;
        if ($urandom_range(0, 4) == 0)
            repeat ($urandom_range(1, 3)) rx_stream.push_back(any_byte());
        queue_token();
        plen = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 40) : $urandom_range(0, 19);
        if ($urandom_range(0, 4) == 0) rx_stream.push_back(CHAR_ZERO);
        queue_text($sformatf("%0d", plen));
        // trailing junk before the colon must be ignored
        if ($urandom_range(0, 5) == 0) begin
            rx_stream.push_back("x");
            rx_stream.push_back(digit_char());
        end
        rx_stream.push_back(CHAR_COLON);
        status_digits = $urandom_range(0, 3) != 0;
        for (int i = 0; i < plen; i++) begin
            if (status_digits && i >= STATUS_FIRST && i < STATUS_END) begin
                case ($urandom_range(0, 7))
                    0:       rx_stream.push_back("/");
                    1:       rx_stream.push_back(CHAR_COLON);
                    default: rx_stream.push_back(digit_char());
                endcase
            end else begin
                rx_stream.push_back(any_byte());
            end
        end
    endfunction

    // Noise and broken frames; lengths kept small so the block never runs away
    function automatic void queue_broken();
        int unsigned cut;
        case ($urandom_range(0, 3))
            0: repeat ($urandom_range(4, 12)) rx_stream.push_back(any_byte());
            1: begin
                // token and digits but no colon yet: the length phase stays open
                queue_token();
                repeat ($urandom_range(0, 2)) rx_stream.push_back(digit_char());
                rx_stream.push_back("/");
            end
            2: begin
                // truncated payload: the next frame gets swallowed as payload
                queue_token();
                queue_text($sformatf("%0d", $urandom_range(1, 30)));
                rx_stream.push_back(CHAR_COLON);
                repeat ($urandom_range(0, 5)) rx_stream.push_back(any_byte());
            end
            default: begin
                cut = $urandom_range(0, token_span() - 1);
                for (int i = 0; i < cut; i++) rx_stream.push_back(tok_bytes[8 * i +: 8]);
                rx_stream.push_back(any_byte());
            end
        endcase
    endfunction

    function automatic void queue_random(input int unsigned count);
        int unsigned base;
        base = rx_stream.size();
        while (rx_stream.size() - base < count) begin
            if ($urandom_range(0, 4) != 0) queue_frame();
            else                           queue_broken();
        end
    endfunction

    // Hold until every byte is taken and every result has arrived, then let it settle
    task automatic wait_idle();
        do @(posedge i_clk);
        while (rx_stream.size() != 0 || s_tvalid || expected_payload.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] value);
        @(negedge i_clk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(negedge i_clk);
        cfg_wr_en <= 1'b0;
        if (idx == CFG_TOKEN_BYTES) tok_bytes = value;
        else                        tok_len   = value[TOK_LEN_W-1:0];
    endtask

    // ------------------------------------------------------------------
    // Test sequence
    // ------------------------------------------------------------------
    initial begin
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed frames under the reset token "+IPD,"
        queue_text("+IPD,0:");                          // empty frame
        queue_text("++IPD,1:x");                        // naive restart loses the frame
        queue_text("+IPD,x5:");                         // no leading digit: length zero
        queue_text("+IPD,2x5:");                        // digits stop at first non-digit
        rx_stream.push_back(8'h00);
        rx_stream.push_back(8'hFF);
        queue_text("+IPD,10:abcdefghi4");               // status from a short frame
        queue_text("+IPD,020:abcdefghi999abcdefgh");    // minimum good frame, top status
        wait_idle();

        // Shrink the token length while a partial match is held
        queue_text("+IPD");
        wait_idle();
        write_reg(CFG_TOKEN_LENGTH, 64'(3));
        queue_text(",2:ab");
        wait_idle();

        // Extreme register settings
        send_idle = 1'b1;
        recv_idle = 1'b1;
        write_reg(CFG_TOKEN_BYTES, '1);
        write_reg(CFG_TOKEN_LENGTH, 64'(15));
        queue_random(RANDOM_CHUNK);
        wait_idle();

        recv_idle = 1'b0;
        write_reg(CFG_TOKEN_BYTES, '0);
        write_reg(CFG_TOKEN_LENGTH, 64'(0));
        queue_random(RANDOM_CHUNK);
        wait_idle();

        // Random tokens, idling mixed per phase
        for (int k = 0; k < 4; k++) begin
            send_idle = $urandom_range(0, 1);
            recv_idle = $urandom_range(0, 1);
            write_reg(CFG_TOKEN_BYTES, {$urandom, $urandom});
            write_reg(CFG_TOKEN_LENGTH, 64'($urandom_range(1, TOKEN_MAX)));
            queue_random(RANDOM_CHUNK);
            wait_idle();
        end

        // Back to the reset token, full idling on both sides
        send_idle = 1'b1;
        recv_idle = 1'b1;
        write_reg(CFG_TOKEN_BYTES, TOKEN_BYTES_RST);
        write_reg(CFG_TOKEN_LENGTH, 64'(TOKEN_LENGTH_RST));
        queue_random(RANDOM_CHUNK);
        // close any frame left open by the random bytes
        rx_stream.push_back(CHAR_COLON);
        repeat (FLUSH_BYTES) rx_stream.push_back("/");
        wait_idle();

        // Saturated length, run flat out on both sides: a wrapped length would
        // end the frame on its first byte, a saturated one keeps it open
        send_idle = 1'b0;
        recv_idle = 1'b0;
        queue_text("+IPD,65537:");
        repeat (OPEN_PAYLOAD) rx_stream.push_back(any_byte());
        wait_idle();

        repeat (20) @(posedge i_clk);
        if (expected_payload.size() != 0) begin
            $error("%0d results never arrived", expected_payload.size());
            fail_count++;
        end
        if (fail_count == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

    // Watchdog: abandon the run as failed if it is still going at CYCLE_LIMIT
    initial begin
        int unsigned cycle_count;
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("tb: failure");
        $finish;
    end

endmodule
